[hdl/hdf_pkg.sv]
// ----------------------------------------------------------------------------
// hdf_pkg
// Shared types, character codes and helpers of the hex-dump formatter.
// ----------------------------------------------------------------------------
package hdf_pkg;

	// bytes shown on one dump line
	localparam int LINE_BYTES = 16;

	// line position codes
	localparam logic [3:0] LAST_POS = 4'd15;
	localparam logic [3:0] SEP_POS  = 4'd8;

	// lengths within one request's text, in characters
	localparam logic [6:0] HEADER_LEN  = 7'd7;
	localparam logic [6:0] HEX_FIELD   = 7'd3;
	localparam logic [6:0] TAB_TO_ASC  = 7'd2;
	localparam logic [6:0] TAB_TO_END  = 7'd17;
	localparam logic [6:0] GROUP_CHARS = 7'd4;
	localparam logic [2:0] FULL_GROUP  = 3'd4;

	// character codes
	localparam logic [7:0] CHAR_NL    = 8'h0a;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_DASH  = 8'h2d;
	localparam logic [7:0] CHAR_DOT   = 8'h2e;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_HEXA  = 8'h57;
	localparam logic [7:0] CHAR_DEL   = 8'h7f;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic last_group;
	} status_t;

	// lowercase hex digit
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) begin
			return CHAR_ZERO + {4'b0000, nib};
		end else begin
			return CHAR_HEXA + {4'b0000, nib};
		end
	endfunction

	// bytes above space and below DEL stand as they are, everything else (space too) is a dot
	function automatic logic [7:0] disp_char(input logic [7:0] b);
		if (b <= CHAR_SPACE || b >= CHAR_DEL) begin
			return CHAR_DOT;
		end else begin
			return b;
		end
	endfunction

endpackage

[hdl/hdf_ctrl.sv]
// ----------------------------------------------------------------------------
// hdf_ctrl
// Controller of the hex-dump formatter: takes a request, then steps the
// datapath through its four-character groups.
// ----------------------------------------------------------------------------
module hdf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  hdf_pkg::status_t  status,
	output hdf_pkg::cmd_t     cmd
);

	hdf_pkg::state_t state_q;
	hdf_pkg::state_t state_nxt;
	logic            emit;
	logic            finishing;

	// a new request may enter while the last group of the previous one loads
	assign emit      = (state_q == hdf_pkg::ST_EMIT);
	assign finishing = emit && status.out_free && status.last_group;
	assign in_stall  = !((state_q == hdf_pkg::ST_IDLE) || finishing);

	// commands
	assign cmd.accept = in_valid && !in_stall;
	assign cmd.load   = emit && status.out_free;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			hdf_pkg::ST_IDLE: begin
				if (cmd.accept) begin
					state_nxt = hdf_pkg::ST_EMIT;
				end
			end
			hdf_pkg::ST_EMIT: begin
				if (cmd.accept) begin
					state_nxt = hdf_pkg::ST_EMIT;
				end else if (finishing) begin
					state_nxt = hdf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = hdf_pkg::ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hdf_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

[hdl/hdf_datapath.sv]
// ----------------------------------------------------------------------------
// hdf_datapath
// Datapath of the hex-dump formatter: dump position, request layout, the
// display column and the four-lane character generator with its output
// register.
// ----------------------------------------------------------------------------
module hdf_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  hdf_pkg::cmd_t     cmd,
	output hdf_pkg::status_t  status,
	input  logic [7:0]        data_byte,
	input  logic              final_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [31:0]       text_chars,
	output logic [2:0]        char_count,
	output logic              run_end
);

	// dump position
	logic [15:0] byte_index_q;
	logic        line_started_q;

	// layout of the current request
	logic [7:0]  item_byte_q;
	logic [3:0]  item_pos_q;
	logic [15:0] item_offset_q;
	logic        nl_q;
	logic [6:0]  hex_start_q;
	logic [6:0]  tab_q;
	logic [6:0]  asc_end_q;
	logic [6:0]  total_q;
	logic [6:0]  grp_q;

	// display column, consumed from the low end while the line closes
	logic [7:0]  col_q     [hdf_pkg::LINE_BYTES];
	logic [7:0]  col_shift [hdf_pkg::LINE_BYTES];

	// output register
	logic        out_valid_q;
	logic [31:0] text_q;
	logic [2:0]  count_q;
	logic        run_end_q;

	// layout of an incoming request
	logic [3:0]  pos_in;
	logic        hdr_in;
	logic        nl_in;
	logic        close_in;
	logic [3:0]  missing_in;
	logic [5:0]  pad_in;
	logic [6:0]  hex_start_in;
	logic [6:0]  tab_in;
	logic [6:0]  asc_end_in;
	logic [6:0]  total_in;

	// group generation
	logic [3:0][7:0] lane_chars;
	logic [2:0]      asc_used;
	logic [6:0]      remain;
	logic [2:0]      group_count;

	assign pos_in       = byte_index_q[3:0];
	assign hdr_in       = (pos_in == 4'd0);
	assign nl_in        = hdr_in && line_started_q;
	assign close_in     = final_byte || (pos_in == hdf_pkg::LAST_POS);
	assign missing_in   = hdf_pkg::LAST_POS - pos_in;
	assign pad_in       = close_in ? ({1'b0, missing_in, 1'b0} + {2'b00, missing_in}) : 6'd0;
	assign hex_start_in = hdr_in ? (hdf_pkg::HEADER_LEN + {6'd0, nl_in}) : 7'd0;
	assign tab_in       = hex_start_in + hdf_pkg::HEX_FIELD + {1'b0, pad_in};
	assign asc_end_in   = tab_in + hdf_pkg::TAB_TO_ASC + {3'b000, pos_in};
	assign total_in     = close_in ? (tab_in + hdf_pkg::TAB_TO_END)
	                               : (hex_start_in + hdf_pkg::HEX_FIELD);

	// dump position and request layout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q   <= 16'd0;
			line_started_q <= 1'b0;
		end else if (cmd.accept) begin
			if (final_byte) begin
				byte_index_q   <= 16'd0;
				line_started_q <= 1'b0;
			end else begin
				byte_index_q   <= byte_index_q + 16'd1;
				line_started_q <= line_started_q || hdr_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_byte_q   <= data_byte;
			item_pos_q    <= pos_in;
			item_offset_q <= byte_index_q;
			nl_q          <= nl_in;
			hex_start_q   <= hex_start_in;
			tab_q         <= tab_in;
			asc_end_q     <= asc_end_in;
			total_q       <= total_in;
		end
	end

	// group pointer
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			grp_q <= 7'd0;
		end else if (cmd.load) begin
			grp_q <= grp_q + hdf_pkg::GROUP_CHARS;
		end
	end

	// four character lanes; display characters come from the column taps
	always_comb begin : lane_gen
		logic [6:0] t;
		logic [6:0] rel;
		lane_chars = '0;
		asc_used   = 3'd0;
		for (int l = 0; l < 4; l++) begin
			t   = grp_q + 7'(l);
			rel = 7'd0;
			if (t >= total_q) begin
				lane_chars[l] = 8'h00;
			end else if (t < {6'd0, nl_q}) begin
				lane_chars[l] = hdf_pkg::CHAR_NL;
			end else if (t < hex_start_q) begin
				rel = t - {6'd0, nl_q};
				case (rel[2:0])
					3'd0: lane_chars[l] = hdf_pkg::hex_char(item_offset_q[15:12]);
					3'd1: lane_chars[l] = hdf_pkg::hex_char(item_offset_q[11:8]);
					3'd2: lane_chars[l] = hdf_pkg::hex_char(item_offset_q[7:4]);
					3'd3: lane_chars[l] = hdf_pkg::hex_char(item_offset_q[3:0]);
					3'd5: lane_chars[l] = hdf_pkg::CHAR_DASH;
					default: lane_chars[l] = hdf_pkg::CHAR_SPACE;
				endcase
			end else if (t < hex_start_q + hdf_pkg::HEX_FIELD) begin
				rel = t - hex_start_q;
				case (rel[1:0])
					2'd0: lane_chars[l] = hdf_pkg::hex_char(item_byte_q[7:4]);
					2'd1: lane_chars[l] = hdf_pkg::hex_char(item_byte_q[3:0]);
					default: begin
						lane_chars[l] = (item_pos_q == hdf_pkg::SEP_POS)
						                ? hdf_pkg::CHAR_DASH : hdf_pkg::CHAR_SPACE;
					end
				endcase
			end else if (t < tab_q) begin
				lane_chars[l] = hdf_pkg::CHAR_SPACE;
			end else if (t == tab_q) begin
				lane_chars[l] = hdf_pkg::CHAR_TAB;
			end else if (t < asc_end_q) begin
				lane_chars[l] = col_q[{2'b00, asc_used[1:0]}];
				asc_used      = asc_used + 3'd1;
			end else begin
				lane_chars[l] = hdf_pkg::CHAR_SPACE;
			end
		end
	end

	// column advances by the display characters just used
	always_comb begin : col_adv
		logic [4:0] src;
		for (int i = 0; i < hdf_pkg::LINE_BYTES; i++) begin
			src = 5'(i) + {2'b00, asc_used};
			if (src < 5'(hdf_pkg::LINE_BYTES)) begin
				col_shift[i] = col_q[src[3:0]];
			end else begin
				col_shift[i] = col_q[i];
			end
		end
	end

	// new display character at its position, otherwise the column shifts on load
	always_ff @(posedge clk) begin
		for (int i = 0; i < hdf_pkg::LINE_BYTES; i++) begin
			if (cmd.accept && (pos_in == 4'(i))) begin
				col_q[i] <= hdf_pkg::disp_char(data_byte);
			end else if (cmd.load) begin
				col_q[i] <= col_shift[i];
			end
		end
	end

	// group size and end of request
	assign remain      = total_q - grp_q;
	assign group_count = (remain >= hdf_pkg::GROUP_CHARS) ? hdf_pkg::FULL_GROUP : remain[2:0];

	assign status.last_group = ((grp_q + hdf_pkg::GROUP_CHARS) >= total_q);
	assign status.out_free   = !out_valid_q || !out_stall;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			text_q    <= lane_chars;
			count_q   <= group_count;
			run_end_q <= status.last_group;
		end
	end

	assign out_valid  = out_valid_q;
	assign text_chars = text_q;
	assign char_count = count_q;
	assign run_end    = run_end_q;

	// a group only loads into a free output register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> status.out_free)
		else $error("group loaded over a waiting result");

	// every shown result carries one to four characters
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (char_count != 3'd0 && char_count <= hdf_pkg::FULL_GROUP))
		else $error("result with bad character count");

	// only the last group of a request may be short
	a_short_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !run_end) |-> (char_count == hdf_pkg::FULL_GROUP))
		else $error("short group before end of request");

	// a new request only enters when the previous one has no group left
	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && cmd.load) |-> status.last_group)
		else $error("request taken while groups remain");

endmodule

[hdl/hex_dump_formatter_top.sv]
// Hex-dump formatter: one data byte per input request becomes hex-dump text at sixteen
// bytes per line, handed out as groups of up to four characters, first character in the
// low byte. A request yields one group per clock cycle while out_stall is low, from one
// group for a plain byte up to nineteen when the first byte of a line also closes it; the
// four-character width of the output register sets that figure, and a new request is
// taken in the cycle its predecessor's last group loads (22 groups per full line of 16
// bytes, about 1.4 per byte on average). A byte marked final closes the line and starts
// the next dump at offset 0000.
// ----------------------------------------------------------------------------
// hex_dump_formatter_top
// Top level of the hex-dump formatter: controller and datapath.
// ----------------------------------------------------------------------------
module hex_dump_formatter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] text_chars,
	output logic [2:0]  char_count,
	output logic        run_end
);

	hdf_pkg::cmd_t    cmd;
	hdf_pkg::status_t status;

	// sequencing
	hdf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// text generation
	hdf_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.text_chars (text_chars),
		.char_count (char_count),
		.run_end    (run_end)
	);

endmodule
